// File: rtl/sellp_pkg.sv
// ----------------------------------------------------------------------------
// sellp_pkg: shared types and constants of the slice size calculator
// Beat structs for both channels, the sequencer state type, the register
// indexes of the configuration port and the saturation limits.
// ----------------------------------------------------------------------------
package sellp_pkg;

  localparam int LEN_W  = 17;
  localparam int OFS_W  = 40;
  localparam int CFG_W  = 7;
  localparam int ELEM_W = 64;

  localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};
  localparam logic [OFS_W-1:0] OFS_MAX  = {OFS_W{1'b1}};
  localparam logic [CFG_W-1:0] ROWS_SAT = {CFG_W{1'b1}};

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ROWS_PER_SLICE = 2'd0;
  localparam cfg_idx_t CFG_STRIDE_MULTIPLE = 2'd1;

  typedef struct packed {
    logic [ELEM_W-1:0] element_bits;
    logic              row_end;
    logic              matrix_end;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] slice_length;
    logic [OFS_W-1:0] slice_start;
    logic             is_final;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_SLICE_OUT,
    ST_FINAL_OUT
  } state_t;

endpackage

// File: rtl/sellp_slice_size_calculator.sv
// ----------------------------------------------------------------------------
// sellp_slice_size_calculator: sliced ELLPACK slice lengths and offsets
// Counts nonzero elements per row, pads row lengths to the stride, keeps the
// slice maximum and emits slice lengths with their running start offsets.
// ----------------------------------------------------------------------------
// An element beat that does not end a row is taken while the block is idle. A
// beat with row_end or matrix_end is taken and starts the rounding unit, which
// finds the padded length one quotient bit per cycle over an 18-bit dividend;
// the block takes no element meanwhile. If the row closes a slice,
// one result beat follows, and matrix_end adds the closing total beat; each
// result beat holds the block until it is taken. After matrix_end all running
// state returns to zero, so a new matrix may follow at once.
module sellp_slice_size_calculator #(
  parameter int ELEMENT_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sellp_pkg::in_t              in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sellp_pkg::out_t             out_data,
  input  logic                        cfg_we,
  input  sellp_pkg::cfg_idx_t         cfg_index,
  input  logic [sellp_pkg::CFG_W-1:0] cfg_wdata
);
  import sellp_pkg::*;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] rps_r, rps_nxt;
  logic [CFG_W-1:0] stride_r, stride_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] max_r, max_nxt;
  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [OFS_W-1:0] ofs_r, ofs_nxt;
  logic             mend_r, mend_nxt;
  out_t             out_r, out_nxt;

  logic             in_acc;
  logic             elem_nz;
  logic             row_done;
  logic [LEN_W-1:0] cnt_inc;
  logic             rnd_done;
  logic [LEN_W-1:0] rnd_len;
  logic [LEN_W-1:0] max_new;
  logic [CFG_W-1:0] rows_new;
  logic [CFG_W-1:0] rps_eff;
  logic             close;
  logic [OFS_W:0]   ofs_sum;

  assign in_acc   = in_valid && !in_stall;
  assign elem_nz  = |in_data.element_bits[ELEMENT_WIDTH-2:0];
  assign row_done = in_data.row_end || in_data.matrix_end;
  assign cnt_inc  = (elem_nz && cnt_r != LEN_MAX) ? cnt_r + LEN_W'(1) : cnt_r;

  sellp_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc && row_done),
    .count  (cnt_inc),
    .stride (stride_r),
    .done   (rnd_done),
    .length (rnd_len)
  );

  always_comb begin
    max_new  = (rnd_len > max_r) ? rnd_len : max_r;
    rows_new = (rows_r != ROWS_SAT) ? rows_r + CFG_W'(1) : rows_r;
    rps_eff  = (rps_r == '0) ? CFG_W'(1) : rps_r;
    close    = (rows_new >= rps_eff) || mend_r;
    ofs_sum  = {1'b0, ofs_r} + (OFS_W + 1)'(max_new);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && row_done) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_done) state_nxt = close ? ST_SLICE_OUT : ST_IDLE;
      end
      ST_SLICE_OUT: begin
        if (!out_stall) state_nxt = mend_r ? ST_FINAL_OUT : ST_IDLE;
      end
      ST_FINAL_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    out_valid  = (state_r == ST_SLICE_OUT) || (state_r == ST_FINAL_OUT);
    rps_nxt    = rps_r;
    stride_nxt = stride_r;
    cnt_nxt    = cnt_r;
    max_nxt    = max_r;
    rows_nxt   = rows_r;
    ofs_nxt    = ofs_r;
    mend_nxt   = mend_r;
    out_nxt    = out_r;
    if (cfg_we) begin
      if (cfg_index == CFG_ROWS_PER_SLICE) rps_nxt = cfg_wdata;
      if (cfg_index == CFG_STRIDE_MULTIPLE) stride_nxt = cfg_wdata;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt  = row_done ? '0 : cnt_inc;
          mend_nxt = in_data.matrix_end;
        end
      end
      ST_ROUND: begin
        if (rnd_done) begin
          if (close) begin
            out_nxt.slice_length = max_new;
            out_nxt.slice_start  = ofs_r;
            out_nxt.is_final     = 1'b0;
            ofs_nxt  = ofs_sum[OFS_W] ? OFS_MAX : ofs_sum[OFS_W-1:0];
            max_nxt  = '0;
            rows_nxt = '0;
          end else begin
            max_nxt  = max_new;
            rows_nxt = rows_new;
          end
        end
      end
      ST_SLICE_OUT: begin
        if (!out_stall && mend_r) begin
          out_nxt.slice_length = '0;
          out_nxt.slice_start  = ofs_r;
          out_nxt.is_final     = 1'b1;
        end
      end
      ST_FINAL_OUT: begin
        // drop the running sum once the total has gone out
        if (!out_stall) begin
          ofs_nxt  = '0;
          mend_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rps_r    <= CFG_W'(64);
      stride_r <= CFG_W'(1);
      cnt_r    <= '0;
      max_r    <= '0;
      rows_r   <= '0;
      ofs_r    <= '0;
      mend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rps_r    <= rps_nxt;
      stride_r <= stride_nxt;
      cnt_r    <= cnt_nxt;
      max_r    <= max_nxt;
      rows_r   <= rows_nxt;
      ofs_r    <= ofs_nxt;
      mend_r   <= mend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// File: rtl/sellp_round.sv
// ----------------------------------------------------------------------------
// sellp_round: round a row count up to a multiple of the stride
// Forms x = count + s - 1 and takes x mod s with a restoring trial subtractor,
// one quotient bit a cycle; the rounded length is x minus that remainder,
// saturated to the length range.
// ----------------------------------------------------------------------------
module sellp_round (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sellp_pkg::LEN_W-1:0]  count,
  input  logic [sellp_pkg::CFG_W-1:0]  stride,
  output logic                         done,
  output logic [sellp_pkg::LEN_W-1:0]  length
);
  import sellp_pkg::*;

  localparam int X_W    = LEN_W + 1;
  localparam int STEP_W = $clog2(X_W + 1);
  localparam logic [STEP_W-1:0] STEPS = STEP_W'(X_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [X_W-1:0]    sh_r, sh_nxt;
  logic [CFG_W-1:0]  rem_r, rem_nxt;
  logic [CFG_W-1:0]  stride_r, stride_nxt;

  logic [CFG_W-1:0]  stride_eff;
  logic [X_W-1:0]    x_start;
  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    trial_diff;
  logic [X_W-1:0]    diff;

  always_comb begin
    stride_eff = (stride == '0) ? CFG_W'(1) : stride;
    x_start    = {1'b0, count} + X_W'(stride_eff) - X_W'(1);
    trial      = {rem_r, sh_r[X_W-1]};
    trial_diff = trial - {1'b0, stride_r};
    diff       = x_r - X_W'(rem_r);
  end

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    step_nxt   = step_r;
    x_nxt      = x_r;
    sh_nxt     = sh_r;
    rem_nxt    = rem_r;
    stride_nxt = stride_r;
    if (start) begin
      busy_nxt   = 1'b1;
      step_nxt   = STEPS;
      x_nxt      = x_start;
      sh_nxt     = x_start;
      rem_nxt    = '0;
      stride_nxt = stride_eff;
    end else if (busy_r) begin
      // restoring step: keep the difference when the trial covers the stride
      rem_nxt  = (trial >= {1'b0, stride_r}) ? trial_diff[CFG_W-1:0] : trial[CFG_W-1:0];
      sh_nxt   = {sh_r[X_W-2:0], 1'b0};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    sh_r     <= sh_nxt;
    rem_r    <= rem_nxt;
    stride_r <= stride_nxt;
  end

  assign done   = done_r;
  assign length = diff[X_W-1] ? LEN_MAX : diff[LEN_W-1:0];

endmodule
